FILE: design/swmt_pkg.sv
// Package for the sliding-window median time core.
// Holds sizes, payload structs, the sequencer states and the select-unit control struct.
// No dependencies.
`default_nettype none

package swmt_pkg;

  // Window depth and field widths
  localparam int WINDOW_SIZE = 11;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = 4;
  localparam int BIT_CNT_W   = $clog2(TIME_W);

  // Input item
  typedef struct packed {
    logic [TIME_W-1:0] block_time;
    logic              chain_start;
  } item_t;

  // Result item
  typedef struct packed {
    logic [TIME_W-1:0] median_time;
    logic [CNT_W-1:0]  window_count;
  } result_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Control from the sequencer to the select unit
  typedef struct packed {
    logic load;  // start a new selection
    logic step;  // consume one bit column
  } sel_ctl_t;

endpackage

`default_nettype wire

FILE: design/swmt_select.sv
// Bit-serial rank select for the median core.
// Takes one bit column (MSB first) per step and builds the k-th smallest value.
// Depends on swmt_pkg.
`default_nettype none

module swmt_select
  import swmt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire sel_ctl_t                ctl,
  input  wire logic [WINDOW_SIZE-1:0]  load_mask,
  input  wire logic [CNT_W-1:0]        load_rank,
  input  wire logic [WINDOW_SIZE-1:0]  col,
  output logic [TIME_W-1:0]            value
);

  logic [WINDOW_SIZE-1:0] cand;
  logic [WINDOW_SIZE-1:0] cand_next;
  logic [CNT_W-1:0]       rank;
  logic [CNT_W-1:0]       rank_next;
  logic [WINDOW_SIZE-1:0] zeros;
  logic [CNT_W-1:0]       num_zeros;
  logic                   bit_val;

  // Candidates holding a zero in this column
  always_comb begin
    zeros     = cand & ~col;
    num_zeros = CNT_W'($countones(zeros));
  end

  // Keep the half that contains the wanted rank
  always_comb begin
    if (num_zeros > rank) begin
      bit_val   = 1'b0;
      cand_next = zeros;
      rank_next = rank;
    end else begin
      bit_val   = 1'b1;
      cand_next = cand & col;
      rank_next = rank - num_zeros;
    end
  end

  // Candidate mask and remaining rank
  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '0;
      rank <= '0;
    end else if (ctl.load) begin
      cand <= load_mask;
      rank <= load_rank;
    end else if (ctl.step) begin
      cand <= cand_next;
      rank <= rank_next;
    end
  end

  // Result bits shift in MSB first
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      value <= {value[TIME_W-2:0], bit_val};
    end
  end

endmodule

`default_nettype wire

FILE: design/sliding_window_median_time_core.sv
// Top level of the sliding-window median time core.
// Holds the timestamp window, the sequencer and the result register.
// Depends on swmt_pkg and swmt_select.
//
// Takes block timestamps in chain order and returns, for each one, the median
// of the last WINDOW_SIZE timestamps (fewer near the chain start), taking the
// upper middle element for an even count. chain_start empties the window
// before the insert. The insert happens at the transfer edge itself. After that
// edge the SCAN state steps once per bit of TIME_W while all window entries
// rotate through their MSB into the bit-serial rank select, then the DONE state
// loads the result register. The next item can be transferred only in IDLE,
// after the load, so the core does not take a new item while one is in flight.
// The window entries are circular shift registers; the bit loop over the
// 32-bit timestamps sets the scan length. The next item is taken as soon as the
// result is loaded, even if it has not yet been transferred out. A result still
// waiting to be transferred out holds off the next load and so stalls the input.
`default_nettype none

module sliding_window_median_time_core
  import swmt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  state_t                 state;
  state_t                 state_next;
  logic [TIME_W-1:0]      win [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] vmask;
  logic [WINDOW_SIZE-1:0] vmask_next;
  logic [CNT_W-1:0]       fill;
  logic [CNT_W-1:0]       fill_next;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [WINDOW_SIZE-1:0] col;
  logic [TIME_W-1:0]      sel_value;
  logic                   take;
  logic                   scan;
  logic                   out_load;
  logic                   last_bit;
  sel_ctl_t               sel_ctl;

  assign take     = item_valid && item_ready;
  assign last_bit = (bit_cnt == BIT_CNT_W'(TIME_W - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_bit) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || result_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_ready = 1'b0;
    scan       = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_SCAN: scan       = 1'b1;
      ST_DONE: out_load   = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count and valid mask after inserting the new timestamp
  always_comb begin
    if (item.chain_start) begin
      vmask_next = WINDOW_SIZE'(1);
      fill_next  = CNT_W'(1);
    end else begin
      vmask_next = WINDOW_SIZE'({vmask, 1'b1});
      fill_next  = (fill == CNT_W'(WINDOW_SIZE)) ? fill : fill + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vmask <= '0;
      fill  <= '0;
    end else if (take) begin
      vmask <= vmask_next;
      fill  <= fill_next;
    end
  end

  // Window: shift line on insert, every entry rotates one bit per scan cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (take) begin
        win[i] <= (i == 0) ? item.block_time : win[(i == 0) ? 0 : i - 1];
      end else if (scan) begin
        win[i] <= {win[i][TIME_W-2:0], win[i][TIME_W-1]};
      end
    end
  end

  // MSB column fed to the select unit
  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      col[i] = win[i][TIME_W-1];
    end
  end

  // Bit counter over the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (take) begin
      bit_cnt <= '0;
    end else if (scan) begin
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
  end

  assign sel_ctl.load = take;
  assign sel_ctl.step = scan;

  swmt_select u_select (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sel_ctl),
    .load_mask (vmask_next),
    .load_rank (fill_next >> 1),
    .col       (col),
    .value     (sel_value)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.median_time  <= sel_value;
      result.window_count <= fill;
    end
  end

endmodule

`default_nettype wire
